/* sv/spblit_pkg.sv */
// Shared types and constants for the one-bit sprite blit unit.
package spblit_pkg;

  // Item kinds on the input channel
  localparam logic KIND_BEGIN = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  // Width of signed framebuffer coordinate arithmetic
  localparam int COORD_W = 18;

  // Queue between the front and back parts
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic               kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        sprite_width;
    logic [15:0]        sprite_height;
    logic [7:0]         sprite_byte;
  } item_t;

  typedef struct packed {
    logic [6:0] pixel_x;
    logic [5:0] pixel_y;
    logic       last_of_byte;
  } pixel_t;

  // One classified byte: column of its first pixel, row, and kept pixels
  // (bit b is the b-th pixel from the left)
  typedef struct packed {
    logic [6:0] base_x;
    logic [5:0] row_y;
    logic [7:0] keep;
  } blit_entry_t;

endpackage

/* sv/one_bit_sprite_clipped_blit_unit.sv */
// Top level of the one-bit sprite blit unit with framebuffer clipping.
//
//   channel | direction | payload | handshake
//   item    | in        | item_t  | item_valid / item_stall
//   pixel   | out       | pixel_t | pixel_valid / pixel_stall
//
// The front takes one item per cycle while the queue has room.
// A byte occupies the back for one cycle per pixel it sets, while the output
// is not stalled; bytes that set nothing, and begin items, never reach the back.
// Output is registered, behind a queue slot and the back's current-byte register.
// Reset (rst, synchronous) empties the queue and ends any sprite.
// item_stall rises only when the four-entry queue is full.
module one_bit_sprite_clipped_blit_unit import spblit_pkg::*; #(
  parameter int FB_WIDTH  = 128,
  parameter int FB_HEIGHT = 64
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   item_valid,
  output logic   item_stall,
  input  item_t  item,
  output logic   pixel_valid,
  input  logic   pixel_stall,
  output pixel_t pixel
);

  logic        push;
  blit_entry_t push_entry;
  logic        pop;
  logic        queue_full;
  logic        queue_not_empty;
  blit_entry_t head;

  assign item_stall = queue_full;

  spblit_front #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  spblit_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (queue_full),
    .not_empty  (queue_not_empty),
    .head       (head)
  );

  spblit_back u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_valid (queue_not_empty),
    .entry       (head),
    .pop         (pop),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel)
  );

endmodule

/* sv/spblit_front.sv */
// Front part: tracks sprite position and classifies each bitmap byte.
module spblit_front import spblit_pkg::*; #(
  parameter int FB_WIDTH  = 128,
  parameter int FB_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  item_t       item,
  input  logic        queue_full,
  output logic        push,
  output blit_entry_t push_entry
);

  localparam logic signed [COORD_W-1:0] FbW = COORD_W'(FB_WIDTH);
  localparam logic signed [COORD_W-1:0] FbH = COORD_W'(FB_HEIGHT);

  logic signed [15:0] origin_x;
  logic signed [15:0] origin_y;
  logic [15:0]        cur_width;
  logic [15:0]        cur_height;
  logic [12:0]        byte_column;
  logic [15:0]        row_count;
  logic               active;

  logic                      accept;
  logic [13:0]               bytes_per_row;
  logic [15:0]               col_px;
  logic [15:0]               rem;
  logic signed [COORD_W-1:0] base_x;
  logic signed [COORD_W-1:0] fy;
  logic signed [COORD_W-1:0] fx [8];
  logic                      row_in;
  logic [7:0]                keep;
  logic [12:0]               col_inc;
  logic [15:0]               row_inc;
  logic                      row_wrap;
  logic                      sprite_done;

  assign accept = item_valid && !queue_full;

  // Classify the pixels of the incoming byte
  always_comb begin
    bytes_per_row = 14'((17'(cur_width) + 17'd7) >> 3);
    col_px    = {byte_column, 3'b000};
    rem       = cur_width - col_px;
    base_x    = signed'({{(COORD_W-16){origin_x[15]}}, origin_x})
              + signed'({{(COORD_W-16){1'b0}}, col_px});
    fy        = signed'({{(COORD_W-16){origin_y[15]}}, origin_y})
              + signed'({{(COORD_W-16){1'b0}}, row_count});
    row_in    = !fy[COORD_W-1] && (fy < FbH);
    for (int b = 0; b < 8; b++) begin
      fx[b]   = base_x + signed'(COORD_W'(b));
      keep[b] = item.sprite_byte[7-b] && ({13'd0, 3'(b)} < rem) && row_in
             && !fx[b][COORD_W-1] && (fx[b] < FbW);
    end
    col_inc     = byte_column + 13'd1;
    row_inc     = row_count + 16'd1;
    row_wrap    = ({1'b0, col_inc} >= bytes_per_row) || (col_inc == 13'd0);
    sprite_done = (row_inc >= cur_height) || (row_inc == 16'd0);
  end

  // Push only bytes that set at least one pixel
  assign push               = accept && (item.kind == KIND_BYTE) && active && (keep != 8'd0);
  assign push_entry.base_x  = base_x[6:0];
  assign push_entry.row_y   = fy[5:0];
  assign push_entry.keep    = keep;

  // Advance sprite state
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      cur_width   <= '0;
      cur_height  <= '0;
      byte_column <= '0;
      row_count   <= '0;
      active      <= 1'b0;
    end else if (accept) begin
      if (item.kind == KIND_BEGIN) begin
        origin_x    <= item.pos_x;
        origin_y    <= item.pos_y;
        cur_width   <= item.sprite_width;
        cur_height  <= item.sprite_height;
        byte_column <= '0;
        row_count   <= '0;
        active      <= (item.sprite_width != 16'd0) && (item.sprite_height != 16'd0);
      end else if (active) begin
        if (row_wrap) begin
          byte_column <= '0;
          row_count   <= row_inc;
          if (sprite_done) begin
            active <= 1'b0;
          end
        end else begin
          byte_column <= col_inc;
        end
      end
    end
  end

endmodule

/* sv/spblit_queue.sv */
// Short queue of classified bytes between the front and back parts.
module spblit_queue import spblit_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  blit_entry_t push_entry,
  input  logic        pop,
  output logic        full,
  output logic        not_empty,
  output blit_entry_t head
);

  blit_entry_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;

  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/spblit_back.sv */
// Back part: walks the kept pixels of each byte and emits coordinates.
module spblit_back import spblit_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        entry_valid,
  input  blit_entry_t entry,
  output logic        pop,
  output logic        pixel_valid,
  input  logic        pixel_stall,
  output pixel_t      pixel
);

  logic [7:0] cur_mask;
  logic [6:0] cur_x;
  logic [5:0] cur_y;

  logic [2:0] idx;
  logic [7:0] mask_left;
  logic       advance;
  logic       out_free;

  // Find the leftmost remaining pixel
  always_comb begin
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (cur_mask[i]) begin
        idx = 3'(i);
      end
    end
    mask_left = cur_mask & (cur_mask - 8'd1);
  end

  assign out_free = !pixel_valid || !pixel_stall;
  assign advance  = (cur_mask != 8'd0) && out_free;
  assign pop      = entry_valid && ((cur_mask == 8'd0) || (advance && (mask_left == 8'd0)));

  // Hold the current byte and load the next one as it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask <= '0;
    end else if (pop) begin
      cur_mask <= entry.keep;
    end else if (advance) begin
      cur_mask <= mask_left;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_x <= entry.base_x;
      cur_y <= entry.row_y;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (advance) begin
      pixel_valid <= 1'b1;
    end else if (!pixel_stall) begin
      pixel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel.pixel_x      <= cur_x + {4'd0, idx};
      pixel.pixel_y      <= cur_y;
      pixel.last_of_byte <= (mask_left == 8'd0);
    end
  end

endmodule

/* sv/spblit_checker.sv */
// Port-level checks for the sprite blit unit and their binding.
module spblit_checker import spblit_pkg::*; #(
  parameter int FB_WIDTH  = 128,
  parameter int FB_HEIGHT = 64
) (
  input logic   clk,
  input logic   rst,
  input logic   item_valid,
  input logic   item_stall,
  input logic   pixel_valid,
  input logic   pixel_stall,
  input pixel_t pixel
);

  // A stalled transaction stays offered
  assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |=> pixel_valid)
    else $error("pixel transaction dropped while stalled");

  // Reset leaves no pixel on the output
  assert property (@(posedge clk) rst |=> !pixel_valid)
    else $error("pixel valid after reset");

  // Emitted coordinates lie inside the framebuffer
  assert property (@(posedge clk) disable iff (rst)
    pixel_valid |-> (int'(pixel.pixel_x) < FB_WIDTH) && (int'(pixel.pixel_y) < FB_HEIGHT))
    else $error("pixel outside framebuffer");

  // Item side is never held off right after reset
  assert property (@(posedge clk) rst |=> !item_stall)
    else $error("item stall after reset");

  // Item valid is driven when not in reset
  assert property (@(posedge clk) disable iff (rst)
    !$isunknown(item_valid))
    else $error("item valid unknown");

endmodule

bind one_bit_sprite_clipped_blit_unit spblit_checker #(
  .FB_WIDTH  (FB_WIDTH),
  .FB_HEIGHT (FB_HEIGHT)
) u_spblit_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item_valid),
  .item_stall  (item_stall),
  .pixel_valid (pixel_valid),
  .pixel_stall (pixel_stall),
  .pixel       (pixel)
);

/* verif/blit_pixel_checker.sv */
// Checker for the sprite blit unit: predicts pixel writes and compares them.
module blit_pixel_checker import spblit_pkg::*; #(
  parameter int FB_W = 128,
  parameter int FB_H = 64
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   item_valid,
  input  logic   item_stall,
  input  item_t  item,
  input  logic   pixel_valid,
  input  logic   pixel_stall,
  input  pixel_t pixel,
  output int     fail_count,
  output int     pending
);

  // Sprite being drawn, as the block should hold it
  logic signed [15:0] org_x, org_y;
  logic [15:0]        span_w, span_h;
  logic [12:0]        col_idx;
  logic [15:0]        row_idx;
  logic               sprite_live;

  pixel_t expected_pixels[$];

  // Advance the sprite state for one item and queue the pixels it sets
  function automatic void blit_item(input item_t it);
    int     row_len;
    int     fy;
    int     fx;
    int     sx;
    bit     row_in;
    pixel_t px;
    pixel_t hits[$];
    if (it.kind == KIND_BEGIN) begin
      org_x       = it.pos_x;
      org_y       = it.pos_y;
      span_w      = it.sprite_width;
      span_h      = it.sprite_height;
      col_idx     = '0;
      row_idx     = '0;
      sprite_live = (it.sprite_width != 0) && (it.sprite_height != 0);
    end else if (sprite_live) begin
      row_len   = (int'(span_w) + 7) / 8;
      fy        = int'(org_y) + int'(row_idx);
      row_in    = (fy >= 0) && (fy < FB_H);
      for (int b = 0; b < 8; b++) begin
        sx = int'(col_idx) * 8 + b;
        // drop padding bits past the sprite width
        if (sx >= int'(span_w)) break;
        if (!it.sprite_byte[7 - b] || !row_in) continue;
        fx = int'(org_x) + sx;
        if (fx < 0 || fx >= FB_W) continue;
        px.pixel_x      = fx[6:0];
        px.pixel_y      = fy[5:0];
        px.last_of_byte = 1'b0;
        hits.push_back(px);
      end
      if (hits.size() > 0) hits[hits.size() - 1].last_of_byte = 1'b1;
      foreach (hits[i]) expected_pixels.push_back(hits[i]);
      // step to the next byte, row, and finally end the sprite
      col_idx = col_idx + 13'd1;
      if (int'(col_idx) >= row_len || col_idx == 0) begin
        col_idx = '0;
        row_idx = row_idx + 16'd1;
        if (row_idx >= span_h || row_idx == 0) sprite_live = 1'b0;
      end
    end
  endfunction

  // Compare each pixel transaction, then predict from each item transaction
  always @(posedge clk) begin
    pixel_t exp_px;
    if (rst) begin
      org_x       = '0;
      org_y       = '0;
      span_w      = '0;
      span_h      = '0;
      col_idx     = '0;
      row_idx     = '0;
      sprite_live = 1'b0;
      fail_count  = 0;
      expected_pixels.delete();
    end else begin
      if (pixel_valid && !pixel_stall) begin
        if (expected_pixels.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected pixel x=%0d y=%0d last=%0d",
                     pixel.pixel_x, pixel.pixel_y, pixel.last_of_byte);
        end else begin
          exp_px = expected_pixels.pop_front();
          if (pixel.pixel_x !== exp_px.pixel_x || pixel.pixel_y !== exp_px.pixel_y ||
              pixel.last_of_byte !== exp_px.last_of_byte) begin
            fail_count++;
            if (fail_count <= 10)
              $display("pixel mismatch: expected x=%0d y=%0d last=%0d, got x=%0d y=%0d last=%0d",
                       exp_px.pixel_x, exp_px.pixel_y, exp_px.last_of_byte,
                       pixel.pixel_x, pixel.pixel_y, pixel.last_of_byte);
          end
        end
      end
      if (item_valid && !item_stall) blit_item(item);
    end
    pending = expected_pixels.size();
  end

endmodule

/* verif/one_bit_sprite_clipped_blit_unit_tb.sv */
// Testbench top for the sprite blit unit: stimulus, receiver stalls and verdict.
module one_bit_sprite_clipped_blit_unit_tb import spblit_pkg::*;;

  localparam int FB_W        = 128;
  localparam int FB_H        = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int STUCK_LIMIT = 5000;
  localparam int PHASE_ITEMS = 115;
  localparam int DRAIN       = 40;

  logic   clk;
  logic   rst         = 1'b1;
  logic   item_valid  = 1'b0;
  logic   item_stall;
  item_t  item        = '0;
  logic   pixel_valid;
  logic   pixel_stall = 1'b0;
  pixel_t pixel;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  logic hold_req    = 1'b0;
  logic hold_used   = 1'b0;
  int hold_left     = 0;
  int stuck_cycles  = 0;

  one_bit_sprite_clipped_blit_unit #(.FB_WIDTH(FB_W), .FB_HEIGHT(FB_H)) dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel      (pixel)
  );

  blit_pixel_checker #(.FB_W(FB_W), .FB_H(FB_H)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel      (pixel),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall the pixel side at random, or hold off for a long stretch once
  always @(posedge clk) begin
    if (rst) begin
      pixel_stall <= 1'b0;
      hold_left   <= 0;
    end else if (hold_req && !hold_used) begin
      hold_used   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      pixel_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      pixel_stall <= 1'b1;
    end else begin
      pixel_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (pixel_valid && !pixel_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("one_bit_sprite_clipped_blit_unit_tb NOT OK");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Offer one item after random idle cycles; return once it is taken
  task automatic push_item(input item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    forever begin
      @(negedge clk);
      if (!item_stall) break;
    end
    @(posedge clk);
  endtask

  // Begin item; the byte field carries junk the block must ignore
  function automatic item_t begin_item(input int x, input int y, input int w, input int h);
    item_t it;
    it.kind          = KIND_BEGIN;
    it.pos_x         = x[15:0];
    it.pos_y         = y[15:0];
    it.sprite_width  = w[15:0];
    it.sprite_height = h[15:0];
    it.sprite_byte   = 8'($urandom);
    return it;
  endfunction

  // Byte item; the begin fields carry junk the block must ignore
  function automatic item_t byte_item(input logic [7:0] d);
    item_t it;
    it.kind          = KIND_BYTE;
    it.pos_x         = 16'($urandom);
    it.pos_y         = 16'($urandom);
    it.sprite_width  = 16'($urandom);
    it.sprite_height = 16'($urandom);
    it.sprite_byte   = d;
    return it;
  endfunction

  // Bitmap byte with empty and full bytes weighted up
  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    int x, y, w, h, nbytes, sel, sent;
    idle_tab  = '{0, 70, 0, 35};
    stall_tab = '{0, 0, 70, 35};
    sent      = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: byte with no sprite, a plain sprite, zero sizes
    push_item(byte_item(8'hFF));
    push_item(begin_item(0, 0, 8, 2));
    push_item(byte_item(8'hFF));
    push_item(byte_item(8'h81));
    push_item(begin_item(5, 5, 0, 4));
    push_item(byte_item(8'hFF));
    push_item(begin_item(5, 5, 8, 0));
    push_item(byte_item(8'hFF));
    // Clip on the left and top edges, padding in the second byte of each row
    push_item(begin_item(-3, -1, 10, 3));
    push_item(byte_item(8'hFF));
    push_item(byte_item(8'hFF));
    push_item(byte_item(8'hFF));
    push_item(byte_item(8'hFF));
    push_item(byte_item(8'h5A));
    push_item(byte_item(8'hC0));
    // Clip on the right edge, then abandon the sprite mid-way
    push_item(begin_item(124, 62, 16, 4));
    push_item(byte_item(8'hFF));
    push_item(byte_item(8'hFF));
    // Extreme positions and sizes, all clipped
    push_item(begin_item(32767, -32768, 65535, 65535));
    push_item(byte_item(8'hFF));
    push_item(begin_item(-32768, 32767, 65535, 65535));
    push_item(byte_item(8'hFF));
    // Bottom-right corner pixel, then a byte after the sprite is done
    push_item(begin_item(127, 63, 1, 1));
    push_item(byte_item(8'h80));
    push_item(byte_item(8'hFF));

    // Random sprites across the idle and stall phases
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = idle_tab[phase];
      stall_pct    <= stall_tab[phase];
      if (phase == 0) hold_req <= 1'b1;
      while (sent < (phase + 1) * PHASE_ITEMS) begin
        sel = $urandom_range(0, 99);
        if (sel < 6) begin
          // zero-size sprite: its bytes do nothing
          w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 40);
          h = (w == 0) ? $urandom_range(0, 8) : 0;
          push_item(begin_item($urandom_range(0, 127), $urandom_range(0, 63), w, h));
          nbytes = $urandom_range(1, 2);
          repeat (nbytes) push_item(byte_item(rand_byte()));
          sent += nbytes + 1;
        end else if (sel < 10) begin
          // huge sprite: a few bytes, then abandoned by the next begin
          push_item(begin_item(int'($urandom_range(0, 160)) - 30,
                               int'($urandom_range(0, 90)) - 20,
                               $urandom_range(1024, 65535), $urandom_range(1, 65535)));
          nbytes = $urandom_range(1, 4);
          repeat (nbytes) push_item(byte_item(rand_byte()));
          sent += nbytes + 1;
        end else begin
          if (sel < 15) begin
            x = int'($urandom_range(0, 65535)) - 32768;
            y = int'($urandom_range(0, 65535)) - 32768;
          end else begin
            x = int'($urandom_range(0, 170)) - 30;
            y = int'($urandom_range(0, 100)) - 25;
          end
          w = $urandom_range(1, 40);
          h = $urandom_range(1, 6);
          nbytes = ((w + 7) / 8) * h;
          // sometimes cut the sprite short
          if ($urandom_range(0, 99) < 8) nbytes = $urandom_range(1, nbytes);
          push_item(begin_item(x, y, w, h));
          repeat (nbytes) push_item(byte_item(rand_byte()));
          sent += nbytes + 1;
          // sometimes trail bytes past the end of the sprite
          if ($urandom_range(0, 99) < 10) begin
            nbytes = $urandom_range(1, 2);
            repeat (nbytes) push_item(byte_item(rand_byte()));
            sent += nbytes;
          end
        end
      end
    end
    item_valid <= 1'b0;

    // Drain outstanding pixels, then watch for strays
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0)
      $display("one_bit_sprite_clipped_blit_unit_tb OK");
    else
      $display("one_bit_sprite_clipped_blit_unit_tb NOT OK");
    $finish;
  end

endmodule
